// ===== hw/rtl/complex_arithmetic_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the complex arithmetic unit
// Implication checks sampled on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Opcodes, pipeline payload types and the 32-bit clamp helper.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_W        = 32;
   localparam int PROD_W        = 64;
   localparam int SUM_W         = 65;
   localparam int QUOT_W        = 32;
   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_CONJ = 3'd4,
      OP_EQ   = 3'd5
   } op_type;

   typedef struct packed {
      logic [PROD_W-1:0] rem;
      logic [QUOT_W-1:0] low;
      logic [QUOT_W-1:0] quo;
      logic              neg;
      logic              ovf;
   } div_lane_type;

   typedef struct packed {
      logic              div_sel;
      logic [PROD_W-1:0] den;
      div_lane_type      lane_re;
      div_lane_type      lane_im;
      logic [DATA_W-1:0] res_re;
      logic [DATA_W-1:0] res_im;
      logic              is_equal;
      logic              div_zero;
      logic              saturated;
   } cell_data_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } clamp_type;

   // clamp a signed 65-bit value to the signed 32-bit range
   function automatic clamp_type clamp65(input logic [SUM_W-1:0] v);
      clamp_type c;
      if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
         c.value = v[DATA_W-1:0];
         c.sat   = 1'b0;
      end else if (v[SUM_W-1]) begin
         c.value = {1'b1, {(DATA_W-1){1'b0}}};
         c.sat   = 1'b1;
      end else begin
         c.value = {1'b0, {(DATA_W-1){1'b1}}};
         c.sat   = 1'b1;
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/cau_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying the opcode and both complex operands.
// ----------------------------------------------------------------------------
interface cau_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic signed [31:0] a_re;
   logic signed [31:0] a_im;
   logic signed [31:0] b_re;
   logic signed [31:0] b_im;

   modport source(output valid, opcode, a_re, a_im, b_re, b_im, input ready);
   modport sink(input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

// ===== hw/rtl/cau_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the complex result and its flags.
// ----------------------------------------------------------------------------
interface cau_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] res_re;
   logic signed [31:0] res_im;
   logic        is_equal;
   logic        div_zero;
   logic        saturated;

   modport source(output valid, res_re, res_im, is_equal, div_zero, saturated,
                  input ready);
   modport sink(input valid, res_re, res_im, is_equal, div_zero, saturated,
                output ready);
endinterface

// ===== hw/rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic front end
// Three stages: products, wide sums, then multiply clamp and divider setup.
// ----------------------------------------------------------------------------
module cau_front #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [2:0]                   opcode,
   input  logic [cau_pkg::DATA_W-1:0]   a_re,
   input  logic [cau_pkg::DATA_W-1:0]   a_im,
   input  logic [cau_pkg::DATA_W-1:0]   b_re,
   input  logic [cau_pkg::DATA_W-1:0]   b_im,
   output logic                         out_valid,
   output cau_pkg::cell_data_type       out_data
);

   localparam int DW = cau_pkg::DATA_W;
   localparam int PW = cau_pkg::PROD_W;
   localparam int SW = cau_pkg::SUM_W;
   localparam int NW = PW + FRAC_BITS;

   // stage 1: products and simple results
   logic              s1_valid_ff, s1_valid_in;
   logic [2:0]        s1_op_ff;
   logic signed [PW-1:0] s1_rr_ff, s1_ii_ff, s1_ri_ff, s1_ir_ff, s1_sr_ff, s1_si_ff;
   logic [DW-1:0]     s1_re_ff, s1_im_ff, s1_re_in, s1_im_in;
   logic              s1_eq_ff, s1_sat_ff, s1_eq_in, s1_sat_in;

   logic [DW:0]       sum_re, sum_im;
   cau_pkg::clamp_type c_re, c_im;

   always_comb begin
      s1_valid_in = in_valid;
      sum_re      = '0;
      sum_im      = '0;
      s1_eq_in    = 1'b0;
      unique case (opcode)
         cau_pkg::OP_ADD: begin
            sum_re = {a_re[DW-1], a_re} + {b_re[DW-1], b_re};
            sum_im = {a_im[DW-1], a_im} + {b_im[DW-1], b_im};
         end
         cau_pkg::OP_SUB: begin
            sum_re = {a_re[DW-1], a_re} - {b_re[DW-1], b_re};
            sum_im = {a_im[DW-1], a_im} - {b_im[DW-1], b_im};
         end
         cau_pkg::OP_CONJ: begin
            sum_re = {a_re[DW-1], a_re};
            sum_im = (DW+1)'(0) - {a_im[DW-1], a_im};
         end
         cau_pkg::OP_EQ: begin
            s1_eq_in = (a_re == b_re) && (a_im == b_im);
         end
         default: begin
            sum_re = '0;
         end
      endcase
      c_re      = cau_pkg::clamp65({{(SW-DW-1){sum_re[DW]}}, sum_re});
      c_im      = cau_pkg::clamp65({{(SW-DW-1){sum_im[DW]}}, sum_im});
      s1_re_in  = c_re.value;
      s1_im_in  = c_im.value;
      s1_sat_in = c_re.sat | c_im.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
      end
      if (en) begin
         s1_op_ff  <= opcode;
         s1_rr_ff  <= $signed(a_re) * $signed(b_re);
         s1_ii_ff  <= $signed(a_im) * $signed(b_im);
         s1_ri_ff  <= $signed(a_re) * $signed(b_im);
         s1_ir_ff  <= $signed(a_im) * $signed(b_re);
         s1_sr_ff  <= $signed(b_re) * $signed(b_re);
         s1_si_ff  <= $signed(b_im) * $signed(b_im);
         s1_re_ff  <= s1_re_in;
         s1_im_ff  <= s1_im_in;
         s1_eq_ff  <= s1_eq_in;
         s1_sat_ff <= s1_sat_in;
      end
   end

   // stage 2: exact 65-bit sums
   logic              s2_valid_ff;
   logic [2:0]        s2_op_ff;
   logic [SW-1:0]     s2_sre_ff, s2_sim_ff, s2_sre_in, s2_sim_in;
   logic [PW-1:0]     s2_den_ff;
   logic [DW-1:0]     s2_re_ff, s2_im_ff;
   logic              s2_eq_ff, s2_sat_ff;
   logic signed [SW-1:0] x_rr, x_ii, x_ri, x_ir;

   always_comb begin
      x_rr = SW'(s1_rr_ff);
      x_ii = SW'(s1_ii_ff);
      x_ri = SW'(s1_ri_ff);
      x_ir = SW'(s1_ir_ff);
      if (s1_op_ff == cau_pkg::OP_MUL) begin
         s2_sre_in = x_rr - x_ii;
         s2_sim_in = x_ri + x_ir;
      end else begin
         s2_sre_in = x_rr + x_ii;
         s2_sim_in = x_ir - x_ri;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_op_ff  <= s1_op_ff;
         s2_sre_ff <= s2_sre_in;
         s2_sim_ff <= s2_sim_in;
         s2_den_ff <= s1_sr_ff + s1_si_ff;
         s2_re_ff  <= s1_re_ff;
         s2_im_ff  <= s1_im_ff;
         s2_eq_ff  <= s1_eq_ff;
         s2_sat_ff <= s1_sat_ff;
      end
   end

   // stage 3: multiply clamp, divider lane setup
   logic                   s3_valid_ff;
   cau_pkg::cell_data_type s3_data_ff, s3_data_in;
   cau_pkg::clamp_type     m_re, m_im;

   function automatic cau_pkg::div_lane_type lane_init(input logic [SW-1:0] s,
                                                       input logic [PW-1:0] den);
      cau_pkg::div_lane_type l;
      logic [PW-1:0]         mag;
      logic [NW-1:0]         num;
      logic [NW-DW-1:0]      hi;
      mag   = s[SW-1] ? PW'((SW)'(0) - s) : s[PW-1:0];
      num   = NW'(mag) << FRAC_BITS;
      hi    = num[NW-1:DW];
      l.rem = PW'(hi);
      l.low = num[DW-1:0];
      l.quo = '0;
      l.neg = s[SW-1];
      l.ovf = PW'(hi) >= den;
      return l;
   endfunction

   always_comb begin
      m_re                 = cau_pkg::clamp65($signed(s2_sre_ff) >>> FRAC_BITS);
      m_im                 = cau_pkg::clamp65($signed(s2_sim_ff) >>> FRAC_BITS);
      s3_data_in.den       = s2_den_ff;
      s3_data_in.lane_re   = lane_init(s2_sre_ff, s2_den_ff);
      s3_data_in.lane_im   = lane_init(s2_sim_ff, s2_den_ff);
      s3_data_in.div_sel   = (s2_op_ff == cau_pkg::OP_DIV) && (s2_den_ff != '0);
      s3_data_in.div_zero  = (s2_op_ff == cau_pkg::OP_DIV) && (s2_den_ff == '0);
      s3_data_in.is_equal  = s2_eq_ff;
      if (s2_op_ff == cau_pkg::OP_MUL) begin
         s3_data_in.res_re    = m_re.value;
         s3_data_in.res_im    = m_im.value;
         s3_data_in.saturated = m_re.sat | m_im.sat;
      end else begin
         s3_data_in.res_re    = s2_re_ff;
         s3_data_in.res_im    = s2_im_ff;
         s3_data_in.saturated = s2_sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

// ===== hw/rtl/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit per cell for both result lanes.
// ----------------------------------------------------------------------------
module cau_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  cau_pkg::cell_data_type in_data,
   output logic                   out_valid,
   output cau_pkg::cell_data_type out_data
);

   localparam int PW = cau_pkg::PROD_W;
   localparam int QW = cau_pkg::QUOT_W;

   function automatic cau_pkg::div_lane_type div_step(input cau_pkg::div_lane_type l,
                                                      input logic [PW-1:0] den);
      cau_pkg::div_lane_type o;
      logic [PW:0]           trial;
      trial = {l.rem, l.low[QW-1]};
      o     = l;
      o.low = {l.low[QW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         o.rem = PW'(trial - {1'b0, den});
         o.quo = {l.quo[QW-2:0], 1'b1};
      end else begin
         o.rem = trial[PW-1:0];
         o.quo = {l.quo[QW-2:0], 1'b0};
      end
      return o;
   endfunction

   logic                   valid_ff;
   cau_pkg::cell_data_type data_ff, data_in;

   always_comb begin
      data_in         = in_data;
      data_in.lane_re = div_step(in_data.lane_re, in_data.den);
      data_in.lane_im = div_step(in_data.lane_im, in_data.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, conjugate and compare on Q16.16 operands.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries an opcode and operands a and b; a transfer happens when
//   valid and ready are both high. rsp_if returns one result per request,
//   in request order, with the same handshake.
//   From a request transfer to rsp_if.valid, a result passes through three
//   front-end stages (products, 65-bit sums, clamp and divider setup), a
//   row of 32 divider cells that each produce one quotient bit, and the
//   output register. Every opcode travels the same path.
//   Throughput is one item per cycle; a new request may follow every cycle.
//   When the receiver stalls with a result pending, the whole pipe holds
//   and req_if.ready drops until the result is taken.
//   Reset clears all valid bits; no result is pending afterward.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   cau_req_if.sink    req_if,
   cau_rsp_if.source  rsp_if
);

   localparam int DW = cau_pkg::DATA_W;
   localparam int QW = cau_pkg::QUOT_W;

   logic                   en;
   logic                   chain_valid [0:QW];
   cau_pkg::cell_data_type chain_data  [0:QW];

   logic                   rsp_valid_ff;
   logic [DW-1:0]          res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic                   is_equal_ff, div_zero_ff, saturated_ff;
   logic                   is_equal_in, div_zero_in, saturated_in;

   // advance whenever the output register is empty or being drained
   assign en           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_if.valid),
      .opcode   (req_if.opcode),
      .a_re     (req_if.a_re),
      .a_im     (req_if.a_im),
      .b_re     (req_if.b_re),
      .b_im     (req_if.b_im),
      .out_valid(chain_valid[0]),
      .out_data (chain_data[0])
   );

   for (genvar i = 0; i < QW; i++) begin : g_cell
      cau_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (chain_valid[i]),
         .in_data  (chain_data[i]),
         .out_valid(chain_valid[i+1]),
         .out_data (chain_data[i+1])
      );
   end

   function automatic cau_pkg::clamp_type quo_clamp(input cau_pkg::div_lane_type l);
      cau_pkg::clamp_type c;
      if (l.ovf) begin
         c.value = l.neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
         c.sat   = 1'b1;
      end else if (!l.neg) begin
         c.sat   = l.quo[QW-1];
         c.value = l.quo[QW-1] ? {1'b0, {(DW-1){1'b1}}} : DW'(l.quo);
      end else begin
         c.sat   = l.quo[QW-1] && (|l.quo[QW-2:0]);
         c.value = c.sat ? {1'b1, {(DW-1){1'b0}}} : DW'(QW'(0) - l.quo);
      end
      return c;
   endfunction

   cau_pkg::clamp_type q_re, q_im;

   always_comb begin
      q_re = quo_clamp(chain_data[QW].lane_re);
      q_im = quo_clamp(chain_data[QW].lane_im);
      is_equal_in = chain_data[QW].is_equal;
      div_zero_in = chain_data[QW].div_zero;
      if (chain_data[QW].div_sel) begin
         res_re_in    = q_re.value;
         res_im_in    = q_im.value;
         saturated_in = q_re.sat | q_im.sat;
      end else begin
         res_re_in    = chain_data[QW].res_re;
         res_im_in    = chain_data[QW].res_im;
         saturated_in = chain_data[QW].saturated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= chain_valid[QW];
      end
      if (en) begin
         res_re_ff    <= res_re_in;
         res_im_ff    <= res_im_in;
         is_equal_ff  <= is_equal_in;
         div_zero_ff  <= div_zero_in;
         saturated_ff <= saturated_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.res_re    = res_re_ff;
   assign rsp_if.res_im    = res_im_ff;
   assign rsp_if.is_equal  = is_equal_ff;
   assign rsp_if.div_zero  = div_zero_ff;
   assign rsp_if.saturated = saturated_ff;

endmodule

// ===== hw/rtl/cau_checker.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit port checker
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_assert.svh"

module cau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] res_re,
   input logic [31:0] res_im,
   input logic        is_equal,
   input logic        div_zero,
   input logic        saturated
);

   logic        rsp_stall;
   logic        res_clear;
   logic [66:0] rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign res_clear = (res_re == '0) && (res_im == '0) && !saturated;
   assign rsp_word  = {res_re, res_im, is_equal, div_zero, saturated};

   // hold a stalled result
   `CAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // a zero divisor gives a zero, unsaturated result
   `CAU_ASSERT_NOW(a_div_zero, clock, reset, rsp_valid && div_zero, res_clear && !is_equal)

   // a compare gives zero parts
   `CAU_ASSERT_NOW(a_eq_zero, clock, reset, rsp_valid && is_equal, res_clear)

   // accept requests whenever no result waits
   `CAU_ASSERT_NOW(a_ready, clock, reset, !rsp_valid, req_ready)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .res_re   (rsp_if.res_re),
   .res_im   (rsp_if.res_im),
   .is_equal (rsp_if.is_equal),
   .div_zero (rsp_if.div_zero),
   .saturated(rsp_if.saturated)
);
